// ===== sv/tcpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

    localparam int ID_W  = 16;
    localparam int AGE_W = 8;
    localparam int CMD_W = 2;
    localparam int CNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_SERVE    = 2'd1,
        CMD_WITHDRAW = 2'd2,
        CMD_QUERY    = 2'd3
    } tcpq_cmd_t;

    typedef struct packed {
        logic             valid;
        logic             pref;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } tcpq_entry_t;

    // broadcast to every cell for the accepted request
    typedef struct packed {
        logic ins;       // insert takes place
        logic rem;       // removal takes place
        logic pref_ins;  // inserted entry is preferred
    } tcpq_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/tcpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcpq_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tcpq_pkg::tcpq_ctrl_t ctrl,
    input  wire tcpq_pkg::tcpq_entry_t new_entry,
    input  wire tcpq_pkg::tcpq_entry_t left_entry,   // cell k-1
    input  wire tcpq_pkg::tcpq_entry_t right_entry,  // cell k+1
    input  wire logic [15:0]          key,
    input  wire logic                 after_in,      // insert point lies before this cell
    input  wire logic                 seen_in,       // removal point lies before this cell
    output logic                      after_out,
    output logic                      seen_out,
    output logic                      match,
    output tcpq_pkg::tcpq_entry_t     entry
);
    import tcpq_pkg::*;

    logic        valid_reg, valid_next;
    logic        pref_reg, pref_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [AGE_W-1:0] age_reg, age_next;
    tcpq_entry_t src;
    logic        load;

    assign entry.valid = valid_reg;
    assign entry.pref  = pref_reg;
    assign entry.id    = id_reg;
    assign entry.age   = age_reg;

    assign match     = valid_reg && (id_reg == key);
    assign seen_out  = seen_in || match;
    assign after_out = ctrl.pref_ins ? !(valid_reg && pref_reg) : !valid_reg;

    always_comb
    begin
        load = 1'b0;
        src  = entry;
        if (ctrl.ins && after_out)
        begin
            load = 1'b1;
            src  = after_in ? left_entry : new_entry;
        end
        else if (ctrl.rem && seen_out)
        begin
            load = 1'b1;
            src  = right_entry;
        end
        valid_next = load ? src.valid : valid_reg;
        pref_next  = load ? src.pref  : pref_reg;
        id_next    = load ? src.id    : id_reg;
        age_next   = load ? src.age   : age_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pref_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pref_reg  <= pref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        age_reg <= age_next;
    end

endmodule

`default_nettype wire

// ===== sv/two_class_priority_queue.sv =====
// Two-class priority queue with cancel.
// Input channel s_axis: tuser carries the command (insert, serve, withdraw,
// query); tdata carries person_id and person_age. Output channel m_axis: one
// result per request with ok, served_id, found_age and count.
// Entries sit in a chain of cells in service order; preferred entries (age at
// or above preferred_age, set through cfg_we/cfg_wdata) join behind the last
// preferred entry, others at the tail. Every cell compares its id with the
// request and shifts left or right in the same cycle.
// The result is registered when the request is accepted.
// Throughput: one request per cycle; a request is taken whenever the output
// register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and at most one further request
// is blocked until it is taken. Reset empties the queue, drops any pending
// result and sets preferred_age to 60. The user must write configuration only
// while no request is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module two_class_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,      // preferred_age
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // person_id[15:0], person_age[23:16]
    input  wire logic [1:0]  s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // ok[0], served_id[16:1], found_age[24:17],
                                             // count[29:25], zero[31:30]
);
    import tcpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [AGE_W-1:0] pref_age_reg;
    logic             out_valid_reg;
    logic [31:0]      out_data_reg, out_data_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW+CNT_W-1:0] count_ext;

    tcpq_entry_t entries [CAPACITY];
    tcpq_entry_t lefts   [CAPACITY];
    tcpq_entry_t rights  [CAPACITY];
    logic [CAPACITY-1:0] hits, afters, seens;
    logic [CAPACITY:0]   after_chain, seen_chain;

    tcpq_ctrl_t  ctrl;
    tcpq_entry_t new_entry;
    tcpq_cmd_t   cmd;
    logic        accept, any_match, full, ok;
    logic [ID_W-1:0]  key, served;
    logic [AGE_W-1:0] age_in, found;

    assign cmd    = tcpq_cmd_t'(s_axis_tuser);
    assign key    = s_axis_tdata[15:0];
    assign age_in = s_axis_tdata[23:16];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign any_match = |hits;
    assign full      = entries[CAPACITY-1].valid;

    assign new_entry.valid = 1'b1;
    assign new_entry.pref  = age_in >= pref_age_reg;
    assign new_entry.id    = key;
    assign new_entry.age   = age_in;

    always_comb
    begin
        ctrl.pref_ins = new_entry.pref;
        ctrl.ins      = accept && (cmd == CMD_INSERT) && !any_match && !full;
        ctrl.rem      = accept && (((cmd == CMD_SERVE) && entries[0].valid)
                                || ((cmd == CMD_WITHDRAW) && any_match));
    end

    assign after_chain[0] = 1'b0;
    assign seen_chain[0]  = (cmd == CMD_SERVE);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign lefts[g] = '0;
            end
            else
            begin : g_mid
                assign lefts[g] = entries[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign rights[g] = '0;
            end
            else
            begin : g_inner
                assign rights[g] = entries[g+1];
            end

            tcpq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  (lefts[g]),
                .right_entry (rights[g]),
                .key         (key),
                .after_in    (after_chain[g]),
                .seen_in     (seen_chain[g]),
                .after_out   (afters[g]),
                .seen_out    (seens[g]),
                .match       (hits[g]),
                .entry       (entries[g])
            );

            assign after_chain[g+1] = afters[g];
            assign seen_chain[g+1]  = seens[g];
        end
    endgenerate

    always_comb
    begin
        found = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            found = found | (hits[k] ? entries[k].age : '0);
        end
    end

    always_comb
    begin
        ok     = 1'b0;
        served = '0;
        case (cmd)
            CMD_INSERT:   ok = ctrl.ins;
            CMD_SERVE:
            begin
                ok     = entries[0].valid;
                served = entries[0].valid ? entries[0].id : '0;
            end
            CMD_WITHDRAW: ok = any_match;
            CMD_QUERY:    ok = any_match;
            default:      ok = 1'b0;
        endcase

        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - 1'b1;
        end
        count_ext = (CW + CNT_W)'(count_next);

        out_data_next = {2'b00, count_ext[CNT_W-1:0],
                         (cmd == CMD_QUERY) ? found : '0, served, ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_age_reg  <= 8'd60;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pref_age_reg <= cfg_wdata;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcpq_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // failed request carries no served id and no age
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[24:1] == 24'd0)
        else $error("failed request with nonzero payload");

    // never both served id and age
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:1] == 16'd0 || m_axis_tdata[24:17] == 8'd0)
        else $error("served id and found age both set");

    // count within capacity (while it fits five bits)
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && CAPACITY < 32 |-> 32'(m_axis_tdata[29:25]) <= 32'(CAPACITY))
        else $error("count above capacity");

    // input is ready whenever the output is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready with empty output");

endmodule

bind two_class_priority_queue tcpq_checker #(.CAPACITY(CAPACITY)) u_tcpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
